>>> rtl/krs_pkg.sv
// krs_pkg: shared types and constants for the keyed record store
// no dependencies
package krs_pkg;
  localparam int STORE_BYTES   = 4096;
  localparam int MAX_KEY_BYTES = 64;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int KW = $clog2(MAX_KEY_BYTES);
  localparam int LW = $clog2(MAX_KEY_BYTES + 2);

  typedef enum logic [2:0] {
    ST_FOUND = 3'd0, ST_ADDED = 3'd1, ST_FULL = 3'd2, ST_KEYLONG = 3'd3, ST_SAVED = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CNT0, S_CNT1, S_REC, S_KEY, S_STAMP, S_NEXT, S_FIT,
    S_WCNT0, S_WCNT1, S_WLEN, S_WKEY, S_WZERO, S_SAVE, S_DONE
  } fsm_t;
endpackage

>>> rtl/krs_if.sv
// krs_if: valid/ready channel interfaces for the keyed record store
// no dependencies
interface krs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  key_byte;
  logic        key_last;
  logic [31:0] stamp_in;
  logic [15:0] group_in;
  modport source (output valid, opcode, key_byte, key_last, stamp_in, group_in, input ready);
  modport sink (input valid, opcode, key_byte, key_last, stamp_in, group_in, output ready);
endinterface

interface krs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [31:0] stamp_out;
  logic [15:0] group_out;
  modport source (output valid, status, found, stamp_out, group_out, input ready);
  modport sink (input valid, status, found, stamp_out, group_out, output ready);
endinterface

>>> rtl/krs_mem.sv
// krs_mem: single-port byte store with registered read
// depends on krs_pkg
module krs_mem import krs_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [STORE_BYTES];

  // one access per cycle
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/keyed_record_store_core.sv
// keyed_record_store_core: top level, sequencer around one byte memory port
// depends on krs_pkg, krs_if, krs_mem
//
//  channel | dir | payload
//  in_*    | in  | opcode, key_byte, key_last, stamp_in, group_in
//  out_*   | out | status, found, stamp_out, group_out
//
// a key byte without last is only buffered; a save writes stamp and group at the save pointer
// a lookup reads the count, then per visited record the length byte and the compared key
// bytes, then steps on; a hit reads stamp and group, an append writes count, length, key
// bytes and six zero bytes; every store byte read has an issue phase and a data phase
// after reset a clearing pass writes 0xff to all STORE_BYTES bytes; no transfer is taken then
// a finished result waits in the output register; the next item is taken once it is sent
module keyed_record_store_core import krs_pkg::*; (
  input logic clk,
  input logic rst_n,
  krs_in_if.sink    in_ch,
  krs_out_if.source out_ch
);
  fsm_t state_r, state_nxt;
  logic [AW:0]   ptr_r, ptr_nxt;        // clear index
  logic [16:0]   at_r, at_nxt;          // record base, wide enough for overflow
  logic [15:0]   count_r, count_nxt;
  logic [15:0]   idx_r, idx_nxt;
  logic [7:0]    rlen_r, rlen_nxt;
  logic [LW-1:0] klen_r, klen_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0]    j_r, j_nxt;             // byte step within a field
  logic [7:0]    kpos_r, kpos_nxt;
  logic          ph_r, ph_nxt;           // 0 issue read, 1 use data
  logic [47:0]   sg_r, sg_nxt;           // stamp and group shift register
  logic [AW-1:0] sp_r, sp_nxt;
  logic [15:0]   hg_r, hg_nxt;
  logic [7:0]    kbuf [MAX_KEY_BYTES];
  logic          ov_r, ov_nxt;
  logic [2:0]    st_r, st_nxt;
  logic          fnd_r, fnd_nxt;
  logic [31:0]   so_r, so_nxt;
  logic          we;
  logic [AW-1:0] maddr;
  logic [7:0]    wdata, rdata, kb_rd_r;
  logic [16:0]   raddr;
  logic          oob_r;
  logic          accept;

  krs_mem u_mem (.clk(clk), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata));

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.status = st_r;
  assign out_ch.found = fnd_r;
  assign out_ch.stamp_out = so_r;
  assign out_ch.group_out = hg_r;

  // key buffer write on key byte transfer
  always_ff @(posedge clk) begin
    if (accept && !in_ch.opcode && klen_r < LW'(MAX_KEY_BYTES))
      kbuf[klen_r[KW-1:0]] <= in_ch.key_byte;
  end

  // registered key buffer read, follows the key position
  always_ff @(posedge clk) kb_rd_r <= kbuf[kpos_nxt[KW-1:0]];

  // out-of-range read flag follows the registered read
  always_ff @(posedge clk) oob_r <= raddr >= 17'(STORE_BYTES);

  // next state
  always_comb begin
    state_nxt = state_r; ptr_nxt = ptr_r; at_nxt = at_r; count_nxt = count_r;
    idx_nxt = idx_r; rlen_nxt = rlen_r; klen_nxt = klen_r; len_nxt = len_r;
    j_nxt = j_r; kpos_nxt = kpos_r; ph_nxt = ph_r;
    sg_nxt = sg_r; sp_nxt = sp_r; hg_nxt = hg_r; ov_nxt = ov_r; st_nxt = st_r;
    fnd_nxt = fnd_r; so_nxt = so_r;
    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == (AW+1)'(STORE_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.opcode) begin
            sg_nxt = {in_ch.stamp_in, in_ch.group_in};
            j_nxt = '0; state_nxt = S_SAVE;
          end else begin
            klen_nxt = (klen_r <= LW'(MAX_KEY_BYTES)) ? klen_r + 1'b1 : klen_r;
            if (in_ch.key_last) begin
              len_nxt = klen_nxt; klen_nxt = '0;
              if (len_nxt > LW'(MAX_KEY_BYTES)) begin
                st_nxt = ST_KEYLONG; state_nxt = S_DONE;
              end else begin
                ph_nxt = 1'b0; state_nxt = S_CNT0;
              end
            end
          end
        end
      end
      S_CNT0: begin
        ph_nxt = !ph_r;
        if (ph_r) begin count_nxt[15:8] = rdata; state_nxt = S_CNT1; end
      end
      S_CNT1: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          count_nxt[7:0] = rdata; at_nxt = 17'd2; idx_nxt = '0;
          if ({count_r[15:8], rdata} == 16'hffff || {count_r[15:8], rdata} == 16'd0)
            state_nxt = S_FIT;
          else state_nxt = S_REC;
        end
      end
      S_REC: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          rlen_nxt = oob_r ? 8'hff : rdata; kpos_nxt = '0;
          if (rlen_nxt != 8'(len_r)) state_nxt = S_NEXT;
          else if (len_r == '0) begin j_nxt = '0; state_nxt = S_STAMP; end
          else state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          if ((oob_r ? 8'hff : rdata) != kb_rd_r) begin
            state_nxt = S_NEXT;
          end else if (kpos_r + 1'b1 == 8'(len_r)) begin
            j_nxt = '0; state_nxt = S_STAMP;
          end else kpos_nxt = kpos_r + 1'b1;
        end
      end
      S_STAMP: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          sg_nxt = {sg_r[39:0], (oob_r ? 8'hff : rdata)};
          j_nxt = j_r + 1'b1;
          if (j_r == 4'd5) begin
            so_nxt = sg_nxt[47:16]; hg_nxt = sg_nxt[15:0]; fnd_nxt = 1'b1;
            sp_nxt = AW'(at_r + 17'(len_r) + 17'd1);
            st_nxt = ST_FOUND; state_nxt = S_DONE;
          end
        end
      end
      S_NEXT: begin
        at_nxt = at_r + 17'(rlen_r) + 17'd8;
        idx_nxt = idx_r + 1'b1;
        if (at_nxt >= 17'(STORE_BYTES)) begin st_nxt = ST_FULL; state_nxt = S_DONE; end
        else if (idx_nxt == count_r) state_nxt = S_FIT;
        else begin ph_nxt = 1'b0; state_nxt = S_REC; end
      end
      S_FIT: begin
        if (at_r + 17'(len_r) + 17'd7 > 17'(STORE_BYTES)) begin
          st_nxt = ST_FULL; state_nxt = S_DONE;
        end else begin
          count_nxt = (count_r == 16'hffff) ? 16'd1 : count_r + 1'b1;
          state_nxt = S_WCNT0;
        end
      end
      S_WCNT0: state_nxt = S_WCNT1;
      S_WCNT1: state_nxt = S_WLEN;
      S_WLEN: begin
        kpos_nxt = '0;
        state_nxt = (len_r == '0) ? S_WZERO : S_WKEY; j_nxt = '0;
      end
      S_WKEY: begin
        kpos_nxt = kpos_r + 1'b1;
        if (kpos_r + 1'b1 == 8'(len_r)) state_nxt = S_WZERO;
      end
      S_WZERO: begin
        j_nxt = j_r + 1'b1;
        if (j_r == 4'd5) begin
          sp_nxt = AW'(at_r + 17'(len_r) + 17'd1);
          st_nxt = ST_ADDED; state_nxt = S_DONE;
        end
      end
      S_SAVE: begin
        sg_nxt = {sg_r[39:0], 8'h00};
        j_nxt = j_r + 1'b1;
        if (j_r == 4'd5) begin st_nxt = ST_SAVED; state_nxt = S_DONE; end
      end
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
          if (st_r != ST_FOUND) begin fnd_nxt = 1'b0; so_nxt = '0; end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_IDLE && accept) fnd_nxt = 1'b0;
  end

  // memory port drive
  always_comb begin
    we = 1'b0; wdata = 8'hff; raddr = '0;
    unique case (state_r)
      S_CLEAR: begin we = 1'b1; raddr = 17'(ptr_r[AW-1:0]); end
      S_CNT0:  raddr = 17'd0;
      S_CNT1:  raddr = 17'd1;
      S_REC:   raddr = at_r;
      S_KEY:   raddr = at_r + 17'd1 + 17'(kpos_r);
      S_STAMP: raddr = at_r + 17'(len_r) + 17'd1 + 17'(j_r);
      S_WCNT0: begin we = 1'b1; raddr = 17'd0; wdata = count_r[15:8]; end
      S_WCNT1: begin we = 1'b1; raddr = 17'd1; wdata = count_r[7:0]; end
      S_WLEN:  begin we = 1'b1; raddr = at_r; wdata = 8'(len_r); end
      S_WKEY:  begin we = 1'b1; raddr = at_r + 17'd1 + 17'(kpos_r); wdata = kb_rd_r; end
      S_WZERO: begin we = 1'b1; raddr = at_r + 17'(len_r) + 17'd1 + 17'(j_r); wdata = 8'h00; end
      S_SAVE:  begin
        we = (18'(sp_r) + 18'd5) < 18'(STORE_BYTES);
        raddr = 17'(sp_r) + 17'(j_r); wdata = sg_r[47:40];
      end
      default: raddr = '0;
    endcase
    maddr = raddr[AW-1:0];
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; ptr_r <= '0; klen_r <= '0; sp_r <= '0; hg_r <= '0;
      ov_r <= 1'b0; ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ptr_r <= ptr_nxt; klen_r <= klen_nxt; sp_r <= sp_nxt;
      hg_r <= hg_nxt; ov_r <= ov_nxt; ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_r <= at_nxt; count_r <= count_nxt; idx_r <= idx_nxt; rlen_r <= rlen_nxt;
    len_r <= len_nxt; j_r <= j_nxt; kpos_r <= kpos_nxt;
    sg_r <= sg_nxt; st_r <= st_nxt; fnd_r <= fnd_nxt; so_r <= so_nxt;
  end

  // checks
  a_found_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.stamp_out == 32'd0) else $error("stamp on miss");
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.found == (out_ch.status == ST_FOUND)))
    else $error("found/status mismatch");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid && state_r == S_IDLE) else $error("ready while busy");
endmodule

>>> tb/krs_checker.sv
// krs_checker: watches both channels of the keyed record store, predicts each result
// and compares it field by field; depends on krs_pkg and krs_if
module krs_checker import krs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  krs_in_if    in_ch,
  krs_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   table_tail
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     status;
    logic        found;
    logic [31:0] stamp;
    logic [15:0] group;
  } lookup_result_t;

  lookup_result_t expected_q[$];

  // shadow copy of the block state
  logic [7:0]  shadow_mem [STORE_BYTES];
  logic [7:0]  key_buf [MAX_KEY_BYTES];
  int          key_cnt;
  int          save_ptr;
  logic [15:0] held_grp;

  function automatic logic [7:0] mem_rd(int a);
    return (a >= STORE_BYTES) ? 8'hff : shadow_mem[a];
  endfunction

  // walk the record table for the collected key, appending it on a miss
  function automatic lookup_result_t run_lookup();
    int len, cnt, at, i, j, rlen;
    logic hit;
    lookup_result_t r;
    len = key_cnt;
    key_cnt = 0;
    r.status = ST_ADDED;
    r.found = 1'b0;
    r.stamp = '0;
    if (len > MAX_KEY_BYTES) begin
      r.status = ST_KEYLONG;
      r.group = held_grp;
      return r;
    end
    cnt = int'({mem_rd(0), mem_rd(1)});
    at = 2;
    if (cnt != 16'hffff) begin
      for (i = 0; i < cnt; i++) begin
        rlen = int'(mem_rd(at));
        if (rlen == len) begin
          hit = 1'b1;
          for (j = 0; j < len; j++)
            if (mem_rd(at + 1 + j) != key_buf[j]) hit = 1'b0;
          if (hit) begin
            r.status = ST_FOUND;
            r.found = 1'b1;
            r.stamp = {mem_rd(at + len + 1), mem_rd(at + len + 2),
                       mem_rd(at + len + 3), mem_rd(at + len + 4)};
            held_grp = {mem_rd(at + len + 5), mem_rd(at + len + 6)};
            save_ptr = at + len + 1;
            r.group = held_grp;
            return r;
          end
        end
        at = at + rlen + 8;
        if (at >= STORE_BYTES) begin
          r.status = ST_FULL;
          r.group = held_grp;
          return r;
        end
      end
    end
    // append a zeroed record if it fits
    if (at + len + 7 > STORE_BYTES) begin
      r.status = ST_FULL;
      r.group = held_grp;
      return r;
    end
    cnt = (cnt == 16'hffff) ? 1 : ((cnt + 1) & 16'hffff);
    shadow_mem[0] = cnt[15:8];
    shadow_mem[1] = cnt[7:0];
    shadow_mem[at] = len[7:0];
    for (j = 0; j < len; j++) shadow_mem[at + 1 + j] = key_buf[j];
    for (j = 0; j < 6; j++) shadow_mem[at + 1 + len + j] = 8'h00;
    save_ptr = at + 1 + len;
    table_tail = at + len + 8;
    r.group = held_grp;
    return r;
  endfunction

  // one accepted input item; returns 1 when it yields a result
  function automatic bit apply_item(logic op, logic [7:0] kb, logic last,
                                    logic [31:0] st, logic [15:0] grp,
                                    output lookup_result_t r);
    r.status = ST_SAVED;
    r.found = 1'b0;
    r.stamp = '0;
    r.group = held_grp;
    if (op) begin
      if (save_ptr + 5 < STORE_BYTES) begin
        shadow_mem[save_ptr]     = st[31:24];
        shadow_mem[save_ptr + 1] = st[23:16];
        shadow_mem[save_ptr + 2] = st[15:8];
        shadow_mem[save_ptr + 3] = st[7:0];
        shadow_mem[save_ptr + 4] = grp[15:8];
        shadow_mem[save_ptr + 5] = grp[7:0];
      end
      return 1'b1;
    end
    if (key_cnt < MAX_KEY_BYTES) key_buf[key_cnt] = kb;
    if (key_cnt <= MAX_KEY_BYTES) key_cnt++;
    if (!last) return 1'b0;
    r = run_lookup();
    return 1'b1;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    table_tail = 2;
  end

  always @(posedge clk) begin
    lookup_result_t exp_r, new_r;
    if (!rst_n) begin
      foreach (shadow_mem[a]) shadow_mem[a] = 8'hff;
      key_cnt = 0;
      save_ptr = 0;
      held_grp = '0;
      table_tail = 2;
      expected_q.delete();
      pending = 0;
    end else begin
      // result transfer: compare with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d found=%0d stamp=%h group=%h",
                   $time, out_ch.status, out_ch.found, out_ch.stamp_out, out_ch.group_out);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_ch.status);
            errors++;
          end
          if (out_ch.found !== exp_r.found) begin
            $display("%0t: found expected %0d actual %0d", $time, exp_r.found, out_ch.found);
            errors++;
          end
          if (out_ch.stamp_out !== exp_r.stamp) begin
            $display("%0t: stamp expected %h actual %h", $time, exp_r.stamp, out_ch.stamp_out);
            errors++;
          end
          if (out_ch.group_out !== exp_r.group) begin
            $display("%0t: group expected %h actual %h", $time, exp_r.group, out_ch.group_out);
            errors++;
          end
        end
      end
      // input transfer: predict
      if (in_ch.valid && in_ch.ready) begin
        if (apply_item(in_ch.opcode, in_ch.key_byte, in_ch.key_last,
                       in_ch.stamp_in, in_ch.group_in, new_r))
          expected_q.push_back(new_r);
      end
      pending = expected_q.size();
    end
  end
endmodule

>>> tb/tb_keyed_record_store_core.sv
// tb_keyed_record_store_core: stimulus, flow control and verdict for the keyed record store
// depends on krs_pkg, krs_if, keyed_record_store_core and krs_checker
module tb_keyed_record_store_core;
  import krs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 600;
  localparam int IDLE_LIMIT   = 40000;
  localparam int POOL_SIZE    = 48;

  logic clk = 1'b0;
  logic rst_n;
  int   errors, pending, table_tail;

  krs_in_if  in_ch ();
  krs_out_if out_ch ();

  keyed_record_store_core uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  krs_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending), .table_tail(table_tail)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: rotating stall patterns plus one long hold-off
  logic hold_request = 1'b0;
  logic hold_started = 1'b0;
  int   hold_left = 0;
  int   rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left = 400;
    end
    if (!rst_n)
      out_ch.ready = 1'b0;
    else if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      case ((rx_cycle / 300) % 3)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        default: out_ch.ready = ((rx_cycle % 3) == 0);
      endcase
    end
  end

  // sender with bursts and gaps
  int items_sent = 0;
  int burst_left = 0;
  task automatic send_item(logic op, logic [7:0] kb, logic last,
                           logic [31:0] st, logic [15:0] grp);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    in_ch.opcode   = op;
    in_ch.key_byte = kb;
    in_ch.key_last = last;
    in_ch.stamp_in = st;
    in_ch.group_in = grp;
    in_ch.valid    = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_save(logic [31:0] st, logic [15:0] grp);
    send_item(1'b1, 8'($urandom), 1'($urandom), st, grp);
  endtask

  // key bytes from key_bytes[from..upto-1], last set on the final one if asked
  logic [7:0] key_bytes [0:71];
  task automatic send_key_part(int from, int upto, bit close);
    for (int i = from; i < upto; i++)
      send_item(1'b0, key_bytes[i], close && (i == upto - 1), $urandom, 16'($urandom));
  endtask

  task automatic send_key(int n);
    send_key_part(0, n, 1'b1);
  endtask

  task automatic fresh_key(int n);
    for (int i = 0; i < n; i++) key_bytes[i] = 8'($urandom);
    send_key(n);
  endtask

  logic [7:0] pool_bytes [POOL_SIZE][8];
  int         pool_len [POOL_SIZE];
  logic [7:0] first_long [64];

  task automatic load_pool(int k);
    for (int i = 0; i < pool_len[k]; i++) key_bytes[i] = pool_bytes[k][i];
  endtask

  initial begin
    int choice, k, cut, n, fill_cnt;
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.key_byte = '0;
    in_ch.key_last = 1'b0;
    in_ch.stamp_in = '0;
    in_ch.group_in = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (pool_len[p]) begin
      pool_len[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      for (int i = 0; i < 8; i++) pool_bytes[p][i] = 8'($urandom);
    end

    // directed: save at reset pointer, erased count start, hits, extremes
    send_save(32'hffff_ffff, 16'hffff);
    key_bytes[0] = 8'h00;
    send_key(1);
    send_key(1);
    send_save(32'hffff_ffff, 16'hffff);
    send_key(1);
    key_bytes[0] = 8'hff;
    send_key(1);
    send_save(32'h0000_0000, 16'h0000);
    send_key(1);
    // save while a key is half collected
    key_bytes[0] = 8'ha5;
    key_bytes[1] = 8'h5a;
    key_bytes[2] = 8'h3c;
    send_key_part(0, 2, 1'b0);
    send_save(32'h1234_5678, 16'h9abc);
    send_key_part(2, 3, 1'b1);
    send_key(3);
    key_bytes[0] = 8'hff;
    send_key(1);

    // random: mostly lookups of known keys and saves
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > 300) hold_request = 1'b1;
      choice = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_SIZE - 1);
      if (choice < 55) begin
        load_pool(k);
        send_key(pool_len[k]);
      end else if (choice < 80) begin
        send_save($urandom, 16'($urandom));
      end else if (choice < 85) begin
        fresh_key($urandom_range(1, 8));
      end else if (choice < 88) begin
        fresh_key($urandom_range(65, 68));
      end else if (choice < 93) begin
        load_pool(k);
        cut = $urandom_range(0, pool_len[k] - 1);
        send_key_part(0, cut, 1'b0);
        send_save($urandom, 16'($urandom));
        send_key_part(cut, pool_len[k], 1'b1);
      end else begin
        // broken sequence: stray bytes with no last, joined to the next key
        load_pool(k);
        send_key_part(0, $urandom_range(1, pool_len[k]), 1'b0);
      end
    end

    // one longest key, then short keys until little room is left
    key_bytes[0] = 8'h11;
    send_key(1);
    for (int i = 0; i < 64; i++) key_bytes[i] = 8'($urandom);
    for (int i = 0; i < 64; i++) first_long[i] = key_bytes[i];
    send_key(64);
    fill_cnt = 0;
    wait (pending == 0);
    @(negedge clk);
    while (table_tail + 40 <= STORE_BYTES) begin
      if (fill_cnt < 256) begin
        key_bytes[0] = 8'(fill_cnt);
        send_key(1);
      end else begin
        key_bytes[0] = 8'(fill_cnt >> 8);
        key_bytes[1] = 8'(fill_cnt);
        send_key(2);
      end
      fill_cnt++;
      wait (pending == 0);
      @(negedge clk);
    end
    // last record ends exactly at the store end, so the next walk runs past it
    n = STORE_BYTES - 7 - table_tail;
    if (n >= 1 && n <= MAX_KEY_BYTES) fresh_key(n);
    fresh_key(2);
    fresh_key(64);
    for (int i = 0; i < 64; i++) key_bytes[i] = first_long[i];
    send_key(64);
    send_save($urandom, 16'($urandom));
    send_key(64);
    fresh_key(70);
    key_bytes[0] = 8'h00;
    send_key(1);
    in_ch.valid = 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> keyed_record_store_core.f
rtl/krs_pkg.sv
rtl/krs_if.sv
rtl/krs_mem.sv
rtl/keyed_record_store_core.sv
tb/krs_checker.sv
tb/tb_keyed_record_store_core.sv
